### rtl/core/gpbe_pkg.sv
// Shared types, constants and helpers for the game-pad button event poller.
package gpbe_pkg;

    // Frame geometry
    localparam int unsigned MAX_FRAME_BYTES     = 9;
    localparam int unsigned FRAME_BYTES_DEFAULT = 9;

    // Reset value of the half period register
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd16;

    // Command bytes sent on the command line
    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_POLL  = 8'h42;
    localparam logic [7:0] CMD_IDLE  = 8'h00;

    // Byte positions inside the received frame
    localparam int unsigned BYTE_MODE    = 1;
    localparam int unsigned BYTE_BTN_LO  = 3;
    localparam int unsigned BYTE_BTN_HI  = 4;
    localparam int unsigned BYTE_RSTK_X  = 5;
    localparam int unsigned BYTE_RSTK_Y  = 6;
    localparam int unsigned BYTE_LSTK_X  = 7;
    localparam int unsigned BYTE_LSTK_Y  = 8;

    // Last bit position inside a byte
    localparam logic [2:0] LAST_BIT = 3'd7;

    // Line levels and frame status after one tick
    typedef struct packed {
        logic        select_n;
        logic        clock_line;
        logic        command_line;
        logic        busy;
        logic        frame_done;
        logic [7:0]  pad_mode;
        logic [15:0] buttons_now;
        logic [15:0] right_stick;
        logic [15:0] left_stick;
    } link_status_t;

    // Command byte sent at a given byte position
    function automatic logic [7:0] cmd_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = CMD_START;
            4'd1:    b = CMD_POLL;
            default: b = CMD_IDLE;
        endcase
        return b;
    endfunction

endpackage

### rtl/core/gpbe_link.sv
// Serial link sequencer: select, clock and command lines, receive shift and frame bytes.
module gpbe_link
    import gpbe_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic         start_poll,
    input  logic         data_in,
    input  logic [15:0]  half_period,
    output link_status_t status
);

    localparam logic [3:0] FRAME_END = 4'(FRAME_BYTES);

    logic        active_reg, active_next;
    logic [3:0]  byte_reg, byte_next;
    logic [2:0]  bit_reg, bit_next;
    logic        phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  rx_reg  [FRAME_BYTES];
    logic [7:0]  rx_next [FRAME_BYTES];
    logic [7:0]  rx_view [MAX_FRAME_BYTES];
    logic        byte_wr;
    logic        done;
    logic [15:0] half_eff;
    logic [16:0] tick_inc;
    logic [3:0]  byte_inc;
    logic [7:0]  cmd_now;

    // Bit timing and frame sequencing for one tick
    always_comb
    begin
        active_next = active_reg;
        byte_next   = byte_reg;
        bit_next    = bit_reg;
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        shift_next  = shift_reg;
        byte_wr     = 1'b0;
        done        = 1'b0;
        half_eff    = (half_period == 16'd0) ? 16'd1 : half_period;
        tick_inc    = {1'b0, tick_reg} + 17'd1;
        byte_inc    = byte_reg + 4'd1;
        if (!active_reg)
        begin
            if (start_poll)
            begin
                active_next = 1'b1;
                byte_next   = 4'd0;
                bit_next    = 3'd0;
                phase_next  = 1'b0;
                tick_next   = 16'd0;
                shift_next  = 8'h00;
            end
        end
        else if (tick_inc < {1'b0, half_eff})
        begin
            tick_next = tick_inc[15:0];
        end
        else
        begin
            tick_next = 16'd0;
            if (!phase_reg)
            begin
                // end of clock low: sample the data line
                if (data_in)
                begin
                    shift_next = shift_reg | (8'h01 << bit_reg);
                end
                phase_next = 1'b1;
            end
            else if (bit_reg != LAST_BIT)
            begin
                bit_next   = bit_reg + 3'd1;
                phase_next = 1'b0;
            end
            else
            begin
                // byte complete
                byte_wr    = 1'b1;
                shift_next = 8'h00;
                bit_next   = 3'd0;
                if (byte_inc >= FRAME_END)
                begin
                    active_next = 1'b0;
                    phase_next  = 1'b1;
                    byte_next   = 4'd0;
                    done        = 1'b1;
                end
                else
                begin
                    byte_next  = byte_inc;
                    phase_next = 1'b0;
                end
            end
        end
    end

    // Received byte store, written at the current byte position
    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            rx_next[i] = (byte_wr && (byte_reg == 4'(i))) ? shift_reg : rx_reg[i];
        end
    end

    // Bytes beyond the frame length read as zero
    for (genvar g = 0; g < MAX_FRAME_BYTES; g++)
    begin : g_view
        if (g < FRAME_BYTES)
        begin : g_live
            assign rx_view[g] = rx_next[g];
        end
        else
        begin : g_none
            assign rx_view[g] = 8'h00;
        end
    end

    // Line levels after this tick
    assign cmd_now = cmd_byte(byte_next);

    always_comb
    begin
        status.select_n     = ~active_next;
        status.clock_line   = active_next ? phase_next : 1'b1;
        status.command_line = active_next ? cmd_now[bit_next] : 1'b0;
        status.busy         = active_next;
        status.frame_done   = done;
        status.pad_mode     = rx_view[BYTE_MODE];
        status.buttons_now  = {~rx_view[BYTE_BTN_HI], ~rx_view[BYTE_BTN_LO]};
        status.right_stick  = {rx_view[BYTE_RSTK_Y], rx_view[BYTE_RSTK_X]};
        status.left_stick   = {rx_view[BYTE_LSTK_Y], rx_view[BYTE_LSTK_X]};
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            byte_reg   <= 4'd0;
            bit_reg    <= 3'd0;
            phase_reg  <= 1'b1;
            tick_reg   <= 16'd0;
            shift_reg  <= 8'h00;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                rx_reg[i] <= 8'h00;
            end
        end
        else if (step)
        begin
            active_reg <= active_next;
            byte_reg   <= byte_next;
            bit_reg    <= bit_next;
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            shift_reg  <= shift_next;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                rx_reg[i] <= rx_next[i];
            end
        end
    end

    // Clock idles high between frames
    a_idle_clock_high: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> phase_reg)
        else $error("clock phase low while no frame is running");

    // Byte position never reaches the frame length
    a_byte_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_reg < FRAME_END)
        else $error("byte position out of frame");

    // A completed frame leaves the link idle on the next cycle
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && done) |=> !active_reg)
        else $error("link still active after frame end");

endmodule

### rtl/core/gpbe_event.sv
// Button change detector: held mask, highest changed button and its new level.
module gpbe_event
    import gpbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        frame_done,
    input  logic [15:0] buttons_now,
    output logic        event_valid,
    output logic [3:0]  button_index,
    output logic        button_pressed,
    output logic [15:0] buttons_held
);

    logic [15:0] prev_reg, prev_next;
    logic [15:0] chg;
    logic [7:0]  chg_sel;
    logic [7:0]  now_sel;
    logic        use_hi;
    logic [2:0]  top_bit;

    assign chg    = buttons_now ^ prev_reg;
    assign use_hi = |chg[15:8];

    // Second button byte takes priority over the first
    assign chg_sel = use_hi ? chg[15:8] : chg[7:0];
    assign now_sel = use_hi ? buttons_now[15:8] : buttons_now[7:0];

    // Highest set bit of the selected change byte
    always_comb
    begin
        top_bit = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (chg_sel[i])
            begin
                top_bit = 3'(i);
            end
        end
    end

    // Event fields, zero when nothing is reported
    always_comb
    begin
        event_valid    = 1'b0;
        button_index   = 4'd0;
        button_pressed = 1'b0;
        if (frame_done && (chg != 16'h0000))
        begin
            event_valid    = 1'b1;
            button_index   = (use_hi ? 4'd15 : 4'd7) - {1'b0, top_bit};
            button_pressed = now_sel[top_bit];
        end
    end

    assign prev_next    = frame_done ? buttons_now : prev_reg;
    assign buttons_held = prev_next;

    // Previous held mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 16'h0000;
        end
        else if (step)
        begin
            prev_reg <= prev_next;
        end
    end

endmodule

### rtl/core/gamepad_poll_button_events.sv
// Top level of the game-pad serial link master with button change events.
//
// Usage: every input transaction is one tick of the serial link, carrying
// start_poll and the sampled data line data_in. Each input transaction gives
// exactly one output transaction with the line levels (select_n, clock_line,
// command_line), busy_res, frame_done, a button event and the last frame's
// pad mode, held buttons and stick bytes, all as they stand after that tick.
// A tick passes an input register and then a result register before its
// result is offered, and one transaction is taken per cycle in both
// directions while out_ready stays high. When the receiver stalls, the
// result register holds and the input register fills; in_ready then drops
// until the result is taken, so no tick is lost.
// half_period_reg is written through cfg_write_en / cfg_write_data; the
// user must write it only while the block is idle, as the block itself
// does not enforce this. Zero acts as one. Reset leaves the link idle with
// select and clock high, half period 16, all received bytes and the held
// mask zero, and both pipeline stages empty.
module gamepad_poll_button_events
    import gpbe_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_poll,
    input  logic        data_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        select_n,
    output logic        clock_line,
    output logic        command_line,
    output logic        busy_res,
    output logic        frame_done,
    output logic        event_valid,
    output logic [3:0]  button_index,
    output logic        button_pressed,
    output logic [7:0]  pad_mode,
    output logic [15:0] buttons_held,
    output logic [15:0] right_stick,
    output logic [15:0] left_stick
);

    logic         half_reg;
    logic [15:0]  half_period_reg;
    logic         s1_valid_reg, s1_valid_next;
    logic         s1_start_reg;
    logic         s1_din_reg;
    logic         out_valid_reg, out_valid_next;
    logic         advance;
    logic         in_take;
    link_status_t status;
    logic         ev_valid;
    logic [3:0]   ev_index;
    logic         ev_pressed;
    logic [15:0]  held;

    logic         select_n_reg, clock_line_reg, command_line_reg, busy_reg;
    logic         frame_done_reg, event_valid_reg, button_pressed_reg;
    logic [3:0]   button_index_reg;
    logic [7:0]   pad_mode_reg;
    logic [15:0]  buttons_held_reg, right_stick_reg, left_stick_reg;

    assign half_reg = 1'b0;

    // Pipeline flow control
    assign advance        = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !s1_valid_reg || advance;
    assign in_take        = in_valid && in_ready;
    assign s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                half_period_reg <= cfg_write_data;
            end
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_start_reg <= start_poll;
            s1_din_reg   <= data_in;
        end
    end

    gpbe_link #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_link (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .start_poll  (s1_start_reg),
        .data_in     (s1_din_reg),
        .half_period (half_period_reg | {15'd0, half_reg}),
        .status      (status)
    );

    gpbe_event u_event (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .frame_done     (status.frame_done),
        .buttons_now    (status.buttons_now),
        .event_valid    (ev_valid),
        .button_index   (ev_index),
        .button_pressed (ev_pressed),
        .buttons_held   (held)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            select_n_reg       <= status.select_n;
            clock_line_reg     <= status.clock_line;
            command_line_reg   <= status.command_line;
            busy_reg           <= status.busy;
            frame_done_reg     <= status.frame_done;
            event_valid_reg    <= ev_valid;
            button_index_reg   <= ev_index;
            button_pressed_reg <= ev_pressed;
            pad_mode_reg       <= status.pad_mode;
            buttons_held_reg   <= held;
            right_stick_reg    <= status.right_stick;
            left_stick_reg     <= status.left_stick;
        end
    end

    assign out_valid      = out_valid_reg;
    assign select_n       = select_n_reg;
    assign clock_line     = clock_line_reg;
    assign command_line   = command_line_reg;
    assign busy_res       = busy_reg;
    assign frame_done     = frame_done_reg;
    assign event_valid    = event_valid_reg;
    assign button_index   = button_index_reg;
    assign button_pressed = button_pressed_reg;
    assign pad_mode       = pad_mode_reg;
    assign buttons_held   = buttons_held_reg;
    assign right_stick    = right_stick_reg;
    assign left_stick     = left_stick_reg;

    // An event is only reported together with frame end
    a_event_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_valid_reg) |-> frame_done_reg)
        else $error("button event without frame end");

    // A frame end result shows the link idle again
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_done_reg) |-> (!busy_reg && select_n_reg))
        else $error("frame end reported while link busy");

    // Each advance produces a result on the next cycle
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register empty after advance");

endmodule
